// ===== rtl/otsu_pkg.sv =====
// Shared types, widths and constants for the Otsu threshold block.
// Used by every module under rtl but otsu_ram; has no dependencies of its own.
package otsu_pkg;

    localparam int MAX_PIXELS_LOG2 = 22;
    localparam int GRAY_LEVELS     = 256;
    localparam int GRAY_W          = 8;
    localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
    localparam int SUM_W           = CNT_W + GRAY_W;
    localparam int A_W             = SUM_W + CNT_W;
    localparam int NUM_W           = 2 * A_W;
    localparam int DEN_W           = 2 * CNT_W;
    localparam int CMP_W           = NUM_W + DEN_W;
    localparam int MA_W            = NUM_W;
    localparam int MB_W            = A_W;
    localparam int P_W             = MA_W + MB_W;
    localparam int FIFO_DEPTH      = 4;

    localparam logic [CNT_W-1:0] PIX_LIMIT = CNT_W'(1) << MAX_PIXELS_LOG2;
    localparam logic [GRAY_W-1:0] LAST_LEVEL = GRAY_W'(GRAY_LEVELS - 1);

    // luminance weights and the reciprocal of three (exact below 2^16)
    localparam logic [7:0]  W_BLUE   = 8'd28;
    localparam logic [7:0]  W_GREEN  = 8'd151;
    localparam logic [7:0]  W_RED    = 8'd77;
    localparam logic [15:0] RECIP3   = 16'd43691;
    localparam int          RECIP3_SH = 17;

    typedef enum logic [1:0] {
        MODE_GREEN = 2'd0,
        MODE_LUMA  = 2'd1,
        MODE_AVG   = 2'd2,
        MODE_ZERO  = 2'd3
    } gray_mode_t;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              last;
    } item_t;

    typedef struct packed {
        logic            start;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic           done;
        logic [P_W-1:0] prod;
    } mul_rsp_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PX_WR,
        BK_SW_INIT,
        BK_SW_RD,
        BK_SW_H,
        BK_MUL_START,
        BK_MUL_WAIT,
        BK_NEXT,
        BK_DONE
    } back_state_t;

    typedef enum logic [2:0] {
        OP_A,
        OP_B,
        OP_N,
        OP_D,
        OP_L,
        OP_R
    } mul_op_t;

endpackage

// ===== rtl/otsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module otsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/otsu_front.sv =====
// Front end: takes pixel beats, holds the gray mode register and
// converts each pixel to a gray level. Depends on otsu_pkg.
module otsu_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  blue,
    input  logic [7:0]                  green,
    input  logic [7:0]                  red,
    input  logic                        last_pixel,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_data,
    input  logic                        fifo_full,
    input  logic                        clearing,
    output logic                        push,
    output otsu_pkg::item_t             push_item
);

    otsu_pkg::gray_mode_t mode_reg;
    logic [15:0] luma;
    logic [9:0]  sum3;
    logic [25:0] avg_prod;
    logic [7:0]  gray;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= otsu_pkg::MODE_LUMA;
        end
        else if (cfg_valid)
        begin
            mode_reg <= otsu_pkg::gray_mode_t'(cfg_data);
        end
    end

    always_comb
    begin
        luma = 16'(blue * otsu_pkg::W_BLUE) + 16'(green * otsu_pkg::W_GREEN)
             + 16'(red * otsu_pkg::W_RED);
        sum3 = 10'(blue) + 10'(green) + 10'(red);
        avg_prod = 26'(sum3) * 26'(otsu_pkg::RECIP3);
        unique case (mode_reg)
            otsu_pkg::MODE_GREEN: gray = green;
            otsu_pkg::MODE_LUMA:  gray = luma[15:8];
            otsu_pkg::MODE_AVG:   gray = avg_prod[otsu_pkg::RECIP3_SH +: 8];
            otsu_pkg::MODE_ZERO:  gray = 8'd0;
            default:              gray = 8'd0;
        endcase
    end

    assign in_stall       = fifo_full | clearing;
    assign push           = in_valid & ~in_stall;
    assign push_item.gray = gray;
    assign push_item.last = last_pixel;

endmodule

// ===== rtl/otsu_fifo.sv =====
// Short queue of classified pixels between front and back ends.
// Depends on otsu_pkg.
module otsu_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  otsu_pkg::item_t din,
    output logic            full,
    input  logic            pop,
    output otsu_pkg::item_t dout,
    output logic            empty
);

    localparam int PTR_W = $clog2(otsu_pkg::FIFO_DEPTH);

    otsu_pkg::item_t  slot_reg [otsu_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (PTR_W+1)'(otsu_pkg::FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/otsu_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on otsu_pkg.
module otsu_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  otsu_pkg::mul_req_t req,
    output otsu_pkg::mul_rsp_t rsp
);

    localparam int STEP_W = $clog2(otsu_pkg::MB_W);

    logic                       busy_reg, done_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [otsu_pkg::P_W-1:0]   mcand_reg, acc_reg;
    logic [otsu_pkg::MB_W-1:0]  mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(otsu_pkg::MB_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg  <= otsu_pkg::P_W'(req.a);
            mplier_reg <= req.b;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== rtl/otsu_back.sv =====
// Back end: histogram update, clearing pass, Otsu sweep and result register.
// Depends on otsu_pkg, otsu_ram and otsu_mul.
module otsu_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fifo_empty,
    input  otsu_pkg::item_t          fifo_item,
    output logic                     pop,
    output logic                     clearing,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               threshold,
    output logic [22:0]              total_pixels,
    output logic                     overflow
);

    localparam int CW = otsu_pkg::CNT_W;
    localparam int GW = otsu_pkg::GRAY_W;

    otsu_pkg::back_state_t state_reg, state_next;
    otsu_pkg::mul_op_t     op_reg, op_next;
    logic [GW-1:0]         t_reg, t_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic                  last_reg, last_next;
    logic                  outv_reg, outv_next;

    logic [GW-1:0]                 gray_reg, gray_next;
    logic [otsu_pkg::SUM_W-1:0]    sftot_reg, sftot_next;
    logic [CW-1:0]                 wb_reg, wb_next, wf_reg, wf_next;
    logic [otsu_pkg::SUM_W-1:0]    sb_reg, sb_next, sf_reg, sf_next;
    logic [otsu_pkg::A_W-1:0]      a_reg, a_next, b_reg, b_next;
    logic [otsu_pkg::NUM_W-1:0]    num_reg, num_next, bestn_reg, bestn_next;
    logic [otsu_pkg::DEN_W-1:0]    den_reg, den_next, bestd_reg, bestd_next;
    logic [otsu_pkg::CMP_W-1:0]    lhs_reg, lhs_next;
    logic [GW-1:0]                 bestt_reg, bestt_next;
    logic [GW-1:0]                 thr_reg, thr_next;
    logic [CW-1:0]                 tot_reg, tot_next;
    logic                          ovo_reg, ovo_next;

    logic                we;
    logic [GW-1:0]       waddr, raddr;
    logic [CW-1:0]       wdata, rdata;
    logic [CW-1:0]       wb_sum, wf_sub;
    logic [otsu_pkg::SUM_W-1:0] ht;
    logic [otsu_pkg::A_W-1:0]   diff;
    otsu_pkg::mul_req_t  req;
    otsu_pkg::mul_rsp_t  rsp;

    otsu_ram #(
        .WIDTH (CW),
        .DEPTH (otsu_pkg::GRAY_LEVELS)
    ) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    otsu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign wb_sum = wb_reg + rdata;
    assign wf_sub = wf_reg - rdata;
    assign ht     = otsu_pkg::SUM_W'(rdata * t_reg);
    assign diff   = (a_reg >= b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        t_next     = t_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        outv_next  = outv_reg;
        gray_next  = gray_reg;
        sftot_next = sftot_reg;
        wb_next    = wb_reg;
        wf_next    = wf_reg;
        sb_next    = sb_reg;
        sf_next    = sf_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        lhs_next   = lhs_reg;
        bestn_next = bestn_reg;
        bestd_next = bestd_reg;
        bestt_next = bestt_reg;
        thr_next   = thr_reg;
        tot_next   = tot_reg;
        ovo_next   = ovo_reg;
        we         = 1'b0;
        waddr      = t_reg;
        wdata      = '0;
        raddr      = t_reg;
        pop        = 1'b0;
        req.start  = 1'b0;
        req.a      = '0;
        req.b      = '0;

        if (outv_reg && !out_stall)
        begin
            outv_next = 1'b0;
        end

        unique case (state_reg)
            otsu_pkg::BK_CLEAR:
            begin
                we = 1'b1;
                t_next = t_reg + 1'b1;
                if (t_reg == otsu_pkg::LAST_LEVEL)
                begin
                    state_next = otsu_pkg::BK_IDLE;
                end
            end
            otsu_pkg::BK_IDLE:
            begin
                raddr = fifo_item.gray;
                if (!fifo_empty)
                begin
                    pop = 1'b1;
                    gray_next = fifo_item.gray;
                    last_next = fifo_item.last;
                    if (count_reg < otsu_pkg::PIX_LIMIT)
                    begin
                        count_next = count_reg + 1'b1;
                        sftot_next = sftot_reg + otsu_pkg::SUM_W'(fifo_item.gray);
                        state_next = otsu_pkg::BK_PX_WR;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (fifo_item.last)
                        begin
                            state_next = otsu_pkg::BK_SW_INIT;
                        end
                    end
                end
            end
            otsu_pkg::BK_PX_WR:
            begin
                we    = 1'b1;
                waddr = gray_reg;
                wdata = rdata + 1'b1;
                state_next = last_reg ? otsu_pkg::BK_SW_INIT : otsu_pkg::BK_IDLE;
            end
            otsu_pkg::BK_SW_INIT:
            begin
                t_next     = '0;
                wb_next    = '0;
                wf_next    = count_reg;
                sb_next    = '0;
                sf_next    = sftot_reg;
                bestn_next = '0;
                bestd_next = otsu_pkg::DEN_W'(1);
                bestt_next = '0;
                state_next = otsu_pkg::BK_SW_RD;
            end
            otsu_pkg::BK_SW_RD:
            begin
                state_next = otsu_pkg::BK_SW_H;
            end
            otsu_pkg::BK_SW_H:
            begin
                // read-clear the bin as it is swept
                we      = 1'b1;
                wb_next = wb_sum;
                wf_next = wf_sub;
                if (wb_sum == '0)
                begin
                    state_next = otsu_pkg::BK_NEXT;
                end
                else if (wf_sub == '0)
                begin
                    state_next = otsu_pkg::BK_DONE;
                end
                else
                begin
                    sb_next    = sb_reg + ht;
                    sf_next    = sf_reg - ht;
                    op_next    = otsu_pkg::OP_A;
                    state_next = otsu_pkg::BK_MUL_START;
                end
            end
            otsu_pkg::BK_MUL_START:
            begin
                req.start = 1'b1;
                unique case (op_reg)
                    otsu_pkg::OP_A:
                    begin
                        req.a = otsu_pkg::MA_W'(sb_reg);
                        req.b = otsu_pkg::MB_W'(wf_reg);
                    end
                    otsu_pkg::OP_B:
                    begin
                        req.a = otsu_pkg::MA_W'(sf_reg);
                        req.b = otsu_pkg::MB_W'(wb_reg);
                    end
                    otsu_pkg::OP_N:
                    begin
                        req.a = otsu_pkg::MA_W'(diff);
                        req.b = diff;
                    end
                    otsu_pkg::OP_D:
                    begin
                        req.a = otsu_pkg::MA_W'(wb_reg);
                        req.b = otsu_pkg::MB_W'(wf_reg);
                    end
                    otsu_pkg::OP_L:
                    begin
                        req.a = num_reg;
                        req.b = otsu_pkg::MB_W'(bestd_reg);
                    end
                    otsu_pkg::OP_R:
                    begin
                        req.a = bestn_reg;
                        req.b = otsu_pkg::MB_W'(den_reg);
                    end
                    default:
                    begin
                        req.a = '0;
                        req.b = '0;
                    end
                endcase
                state_next = otsu_pkg::BK_MUL_WAIT;
            end
            otsu_pkg::BK_MUL_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = otsu_pkg::BK_MUL_START;
                    unique case (op_reg)
                        otsu_pkg::OP_A:
                        begin
                            a_next  = rsp.prod[otsu_pkg::A_W-1:0];
                            op_next = otsu_pkg::OP_B;
                        end
                        otsu_pkg::OP_B:
                        begin
                            b_next  = rsp.prod[otsu_pkg::A_W-1:0];
                            op_next = otsu_pkg::OP_N;
                        end
                        otsu_pkg::OP_N:
                        begin
                            num_next = rsp.prod[otsu_pkg::NUM_W-1:0];
                            op_next  = otsu_pkg::OP_D;
                        end
                        otsu_pkg::OP_D:
                        begin
                            den_next = rsp.prod[otsu_pkg::DEN_W-1:0];
                            op_next  = otsu_pkg::OP_L;
                        end
                        otsu_pkg::OP_L:
                        begin
                            lhs_next = rsp.prod[otsu_pkg::CMP_W-1:0];
                            op_next  = otsu_pkg::OP_R;
                        end
                        otsu_pkg::OP_R:
                        begin
                            // strictly larger variance wins
                            if (lhs_reg > rsp.prod[otsu_pkg::CMP_W-1:0])
                            begin
                                bestn_next = num_reg;
                                bestd_next = den_reg;
                                bestt_next = t_reg;
                            end
                            state_next = otsu_pkg::BK_NEXT;
                        end
                        default:
                        begin
                            state_next = otsu_pkg::BK_NEXT;
                        end
                    endcase
                end
            end
            otsu_pkg::BK_NEXT:
            begin
                if (t_reg == otsu_pkg::LAST_LEVEL)
                begin
                    state_next = otsu_pkg::BK_DONE;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = otsu_pkg::BK_SW_RD;
                end
            end
            otsu_pkg::BK_DONE:
            begin
                // hold until the result register is free
                if (!outv_reg || !out_stall)
                begin
                    outv_next  = 1'b1;
                    thr_next   = (bestt_reg == '0) ? GW'(1) : bestt_reg;
                    tot_next   = count_reg;
                    ovo_next   = ovf_reg;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    sftot_next = '0;
                    state_next = otsu_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = otsu_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= otsu_pkg::BK_CLEAR;
            op_reg    <= otsu_pkg::OP_A;
            t_reg     <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
            outv_reg  <= 1'b0;
            sftot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            t_reg     <= t_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
            outv_reg  <= outv_next;
            sftot_reg <= sftot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gray_reg  <= gray_next;
        wb_reg    <= wb_next;
        wf_reg    <= wf_next;
        sb_reg    <= sb_next;
        sf_reg    <= sf_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        lhs_reg   <= lhs_next;
        bestn_reg <= bestn_next;
        bestd_reg <= bestd_next;
        bestt_reg <= bestt_next;
        thr_reg   <= thr_next;
        tot_reg   <= tot_next;
        ovo_reg   <= ovo_next;
    end

    assign clearing     = (state_reg == otsu_pkg::BK_CLEAR);
    assign out_valid    = outv_reg;
    assign threshold    = thr_reg;
    assign total_pixels = tot_reg;
    assign overflow     = ovo_reg;

endmodule

// ===== rtl/otsu_threshold_from_pixels.sv =====
// Top level of the Otsu threshold block: front end, queue, back end.
// Depends on otsu_pkg, otsu_front, otsu_fifo and otsu_back.
//
// Usage:
//   Pixel channel (in_valid/in_stall): one beat carries blue, green, red and
//   last_pixel. A beat is taken when in_valid is high and in_stall is low.
//   Result channel (out_valid/out_stall): one beat per image with threshold,
//   total_pixels and overflow, sent after the last pixel's beat.
//   Config channel (cfg_valid/cfg_ready): cfg_data sets the gray mode;
//   cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   The front end takes one pixel per cycle into a four-entry queue while it
//   is not full and no clearing pass runs; the back end retires a pixel by a
//   histogram read, then a write through the one RAM port pair, and pops no
//   new pixel until that write is done. After the last pixel the sweep visits
//   each gray level; below the first occupied level it skips the six 54-step
//   shift-add multiplies, and it ends at the first level with no pixel above.
// Reset: a clearing pass over every gray level zeroes the histogram; in_stall
//   is high while it runs. gray mode resets to weighted luminance.
// A stalled result holds in its register; pixels of the next image keep
//   flowing until the next result is ready to be loaded.
module otsu_threshold_from_pixels (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  threshold,
    output logic [22:0] total_pixels,
    output logic        overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    logic            fifo_full, fifo_empty, push, pop, clearing;
    otsu_pkg::item_t push_item, pop_item;

    otsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .last_pixel (last_pixel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fifo_full  (fifo_full),
        .clearing   (clearing),
        .push       (push),
        .push_item  (push_item)
    );

    otsu_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_item),
        .full  (fifo_full),
        .pop   (pop),
        .dout  (pop_item),
        .empty (fifo_empty)
    );

    otsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_empty   (fifo_empty),
        .fifo_item    (pop_item),
        .pop          (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .threshold    (threshold),
        .total_pixels (total_pixels),
        .overflow     (overflow)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for otsu_threshold_from_pixels: directed table, then random images.
// Checked against typed table results or a histogram/Otsu predictor; depends on otsu_pkg.
`timescale 1ns / 100ps

module tb;

    localparam int ITEM_TARGET = 1950;
    localparam int DRAIN_CYC   = 32;
    localparam longint CYC_LIMIT = 40_000_000;

    typedef struct {
        logic                 set_mode;
        otsu_pkg::gray_mode_t mode;
        logic [7:0]           b;
        logic [7:0]           g;
        logic [7:0]           r;
        logic                 last;
        logic                 typed;
        logic [7:0]           thr;
        int                   total;
    } pix_row_t;

    typedef struct {
        logic [7:0]  thr;
        logic [22:0] total;
        logic        ovf;
    } otsu_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        last_pixel;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  threshold;
    logic [22:0] total_pixels;
    logic        overflow;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    // predictor state
    longint               hist [otsu_pkg::GRAY_LEVELS];
    longint               pix_count;
    logic                 pix_ovf;
    otsu_pkg::gray_mode_t cur_mode;

    otsu_res_t  pending_res [$];
    int         err_count;
    longint     cycles;
    int         sent;
    logic       quiet;

    otsu_threshold_from_pixels dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .last_pixel  (last_pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .threshold   (threshold),
        .total_pixels(total_pixels),
        .overflow    (overflow),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] gray_level(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int s;
        case (cur_mode)
            otsu_pkg::MODE_GREEN: return g;
            otsu_pkg::MODE_LUMA:
            begin
                s = (int'(b) * 28 + int'(g) * 151 + int'(r) * 77) >> 8;
                return s[7:0];
            end
            otsu_pkg::MODE_AVG:
            begin
                s = (int'(b) + int'(g) + int'(r)) / 3;
                return s[7:0];
            end
            default: return 8'd0;
        endcase
    endfunction

    // exact between-class variance compare: num/den against best_n/best_d
    function automatic logic [7:0] otsu_level();
        longint wb, wf, sb, sf, h;
        logic [255:0] ta, tb2, diff, num, den, best_n, best_d;
        int best_t;
        wb = 0; wf = 0; sb = 0; sf = 0;
        best_n = 0; best_d = 1; best_t = 0;
        for (int t = 0; t < otsu_pkg::GRAY_LEVELS; t++)
        begin
            wf += hist[t];
            sf += hist[t] * t;
        end
        for (int t = 0; t < otsu_pkg::GRAY_LEVELS; t++)
        begin
            h = hist[t];
            wb += h;
            wf -= h;
            if (wb == 0)
                continue;
            if (wf == 0)
                break;
            sb += h * t;
            sf -= h * t;
            ta   = 256'(sb) * 256'(wf);
            tb2  = 256'(sf) * 256'(wb);
            diff = (ta >= tb2) ? ta - tb2 : tb2 - ta;
            num  = diff * diff;
            den  = 256'(wb) * 256'(wf);
            if (num * best_d > best_n * den)
            begin
                best_n = num;
                best_d = den;
                best_t = t;
            end
        end
        return (best_t == 0) ? 8'd1 : 8'(best_t);
    endfunction

    // fold one accepted pixel into the histogram; returns 1 with a result on a last pixel
    function automatic logic count_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                         logic last, output otsu_res_t res);
        if (pix_count < (longint'(1) << otsu_pkg::MAX_PIXELS_LOG2))
        begin
            hist[gray_level(b, g, r)]++;
            pix_count++;
        end
        else
            pix_ovf = 1'b1;
        if (!last)
            return 1'b0;
        res.thr   = otsu_level();
        res.total = 23'(pix_count);
        res.ovf   = pix_ovf;
        foreach (hist[i])
            hist[i] = 0;
        pix_count = 0;
        pix_ovf   = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_res.size() == 0)
                report_mismatch("unexpected result beat, threshold", threshold, 0);
            else
            begin
                otsu_res_t want;
                want = pending_res.pop_front();
                if (threshold !== want.thr)
                    report_mismatch("threshold", threshold, want.thr);
                if (total_pixels !== want.total)
                    report_mismatch("total_pixels", total_pixels, want.total);
                if (overflow !== want.ovf)
                    report_mismatch("overflow", overflow, want.ovf);
            end
        end
    end

    // result-side stall: random hold before each beat, none while quiet
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(17);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic last,
                              logic typed, otsu_res_t typed_res);
        int gap;
        otsu_res_t res;
        gap = quiet ? 0 : $urandom_range(17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        blue       <= b;
        green      <= g;
        red        <= r;
        last_pixel <= last;
        do @(posedge clk); while (in_stall);
        if (count_pixel(b, g, r, last, res))
            pending_res.push_back(typed ? typed_res : res);
        sent++;
    endtask

    // hold until the block has drained, then let the pixel queue settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_mode(otsu_pkg::gray_mode_t m);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    pix_row_t  dir_rows [$];
    otsu_res_t no_res;

    task automatic add_row(logic set_mode, otsu_pkg::gray_mode_t m, int b, int g, int r,
                           logic last, logic typed = 1'b0, int thr = 0, int total = 0);
        pix_row_t row;
        row = '{set_mode, m, 8'(b), 8'(g), 8'(r), last, typed, 8'(thr), total};
        dir_rows.push_back(row);
    endtask

    initial
    begin
        int img_len;
        int lo, hi;
        otsu_res_t typed_res;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        blue       = '0;
        green      = '0;
        red        = '0;
        last_pixel = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = otsu_pkg::MODE_LUMA;
        cycles     = 0;
        err_count  = 0;
        sent       = 0;
        quiet      = 1'b0;
        no_res     = '{8'd0, 23'd0, 1'b0};
        foreach (hist[i])
            hist[i] = 0;
        pix_count = 0;
        pix_ovf   = 1'b0;
        cur_mode  = otsu_pkg::MODE_LUMA;

        // single-pixel images, full-scale and zero
        add_row(1'b0, otsu_pkg::MODE_LUMA, 255, 255, 255, 1'b1, 1'b1, 1, 1);
        add_row(1'b0, otsu_pkg::MODE_LUMA, 0, 0, 0, 1'b1, 1'b1, 1, 1);
        // two extreme levels: best split at level zero, reported as one
        add_row(1'b1, otsu_pkg::MODE_GREEN, 255, 0, 255, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_GREEN, 0, 255, 0, 1'b1, 1'b1, 1, 2);
        add_row(1'b0, otsu_pkg::MODE_GREEN, 0, 10, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_GREEN, 0, 20, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_GREEN, 0, 200, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_GREEN, 0, 210, 0, 1'b1);
        add_row(1'b1, otsu_pkg::MODE_AVG, 255, 255, 255, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_AVG, 1, 0, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_AVG, 0, 2, 1, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_AVG, 128, 64, 32, 1'b1);
        // all pixels map to zero
        add_row(1'b1, otsu_pkg::MODE_ZERO, 12, 200, 44, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_ZERO, 255, 0, 255, 1'b1, 1'b1, 1, 2);
        add_row(1'b1, otsu_pkg::MODE_LUMA, 255, 0, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_LUMA, 0, 255, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_LUMA, 0, 0, 255, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_LUMA, 0, 0, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_LUMA, 255, 255, 255, 1'b1);
        // levels 10, 10, 20 and 30: the best split is at level 10
        add_row(1'b1, otsu_pkg::MODE_GREEN, 0, 10, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_GREEN, 0, 10, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_GREEN, 0, 20, 0, 1'b0);
        add_row(1'b0, otsu_pkg::MODE_GREEN, 0, 30, 0, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_mode)
                write_mode(dir_rows[i].mode);
            typed_res = '{dir_rows[i].thr, 23'(dir_rows[i].total), 1'b0};
            send_pixel(dir_rows[i].b, dir_rows[i].g, dir_rows[i].r, dir_rows[i].last,
                       dir_rows[i].typed, typed_res);
        end

        while (sent < ITEM_TARGET)
        begin
            if ($urandom_range(3) == 0)
                write_mode(otsu_pkg::gray_mode_t'($urandom_range(3)));
            quiet = ($urandom_range(4) == 0);
            img_len = ($urandom_range(15) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 30);
            // mostly two clusters, sometimes fully random pixels
            lo = $urandom_range(255);
            hi = $urandom_range(255);
            for (int k = 0; k < img_len; k++)
            begin
                if ($urandom_range(3) == 0)
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                               k == img_len - 1, 1'b0, no_res);
                else if ($urandom_range(1))
                    send_pixel(8'(lo + $urandom_range(3)), 8'(lo + $urandom_range(3)),
                               8'(lo), k == img_len - 1, 1'b0, no_res);
                else
                    send_pixel(8'(hi), 8'(hi - $urandom_range(3)),
                               8'(hi - $urandom_range(3)), k == img_len - 1, 1'b0, no_res);
            end
        end

        wait_idle();
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
